/* rtl/core/dnle_pkg.sv */
`default_nettype none
package dnle_pkg;

	localparam int MAX_LABEL_DEF = 63;
	localparam int MAX_NAME_DEF  = 255;

	localparam logic [7:0] SEP_CHAR = 8'h2E;
	localparam logic [7:0] END_CHAR = 8'h00;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_NAME  = 2'd1,
		ERR_LABEL = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_DATA,
		ST_ERR
	} state_t;

endpackage
`default_nettype wire

/* rtl/core/dnle_ram.sv */
`default_nettype none
module dnle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/dns_name_label_encoder.sv */
// DNS name encoder, uncompressed wire format.
// Input channel (in_valid / in_stall / ch): one name character per transfer,
// 0x2E separates labels, 0x00 ends the name.
// Output channel (out_valid / out_stall / out_byte, root_follows, last,
// error_code): one wire byte per transfer. A dot or the end character yields
// the label length byte, then the buffered label bytes. root_follows marks
// an implied root zero after the final byte; last marks the end of a name.
// An overlong label or name gives one error transfer with last set; input is
// then dropped up to the end character.
// Throughput: a plain character is one write into the label RAM. A dot or end
// character gives its own transfer, the length byte, then the label bytes, one
// per cycle while out_stall is low, set by the single read port of the label
// RAM. A dot/end transfer moves the FSM to ST_LEN, which loads the length byte
// into the output register.
// in_stall is high while a label is being read out or an error is pending.
// When out_stall is high the output register holds and the read-out pauses.
// Reset clears all counters and the output valid flag; the label RAM is not
// cleared, only entries written in the current label are read.
`default_nettype none
module dns_name_label_encoder #(
	parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
	parameter int MAX_NAME  = dnle_pkg::MAX_NAME_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] ch,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            root_follows,
	output logic            last,
	output logic [1:0]      error_code
);

	localparam int LCW = $clog2(MAX_LABEL + 1);
	localparam int NCW = $clog2(MAX_NAME + 1);
	localparam int AW  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

	dnle_pkg::state_t state_q, state_d;
	logic [LCW-1:0] lcnt_q, lcnt_d;
	logic [LCW-1:0] idx_q, idx_d;
	logic [NCW-1:0] ncnt_q, ncnt_d;
	logic           err_hold_q, err_hold_d;
	logic           final_q, final_d;
	dnle_pkg::err_t ecode_q, ecode_d;

	logic           ov_q;
	logic [7:0]     obyte_q;
	logic           oroot_q;
	logic           olast_q;
	logic [1:0]     oerr_q;

	logic           free;
	logic           ld;
	logic [7:0]     ld_byte;
	logic           ld_root;
	logic           ld_last;
	logic [1:0]     ld_err;

	logic           ram_we;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	logic           lbl_end;
	logic [LCW-1:0] idx_nxt;

	// write and read phases never overlap (in_stall during read-out)
	dnle_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LABEL),
		.AW   (AW)
	) u_label_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(lcnt_q)),
		.wdata(ch),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign free     = !ov_q || !out_stall;
	assign in_stall = (state_q != dnle_pkg::ST_IDLE);
	assign idx_nxt  = idx_q + LCW'(1);
	assign lbl_end  = ({1'b0, idx_q} + (LCW+1)'(1)) == {1'b0, lcnt_q};

	always_comb begin
		state_d    = state_q;
		lcnt_d     = lcnt_q;
		idx_d      = idx_q;
		ncnt_d     = ncnt_q;
		err_hold_d = err_hold_q;
		final_d    = final_q;
		ecode_d    = ecode_q;
		ld         = 1'b0;
		ld_byte    = 8'h00;
		ld_root    = 1'b0;
		ld_last    = 1'b0;
		ld_err     = dnle_pkg::ERR_NONE;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = '0;

		case (state_q)
			dnle_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (ch == dnle_pkg::END_CHAR) begin
						ncnt_d = '0;
						if (err_hold_q) begin
							lcnt_d     = '0;
							err_hold_d = 1'b0;
						end else begin
							final_d = 1'b1;
							state_d = dnle_pkg::ST_LEN;
						end
					end else if (err_hold_q) begin
						// dropped until the end character
					end else if (ncnt_q >= NCW'(MAX_NAME)) begin
						err_hold_d = 1'b1;
						ecode_d    = dnle_pkg::ERR_NAME;
						state_d    = dnle_pkg::ST_ERR;
					end else if (ch == dnle_pkg::SEP_CHAR) begin
						ncnt_d  = ncnt_q + NCW'(1);
						final_d = 1'b0;
						state_d = dnle_pkg::ST_LEN;
					end else if (lcnt_q >= LCW'(MAX_LABEL)) begin
						err_hold_d = 1'b1;
						ecode_d    = dnle_pkg::ERR_LABEL;
						state_d    = dnle_pkg::ST_ERR;
					end else begin
						ram_we = 1'b1;
						lcnt_d = lcnt_q + LCW'(1);
						ncnt_d = ncnt_q + NCW'(1);
					end
				end
			end
			dnle_pkg::ST_LEN: begin
				if (free) begin
					ld      = 1'b1;
					ld_byte = 8'(lcnt_q);
					ld_last = final_q && (lcnt_q == '0);
					if (lcnt_q == '0) begin
						state_d = dnle_pkg::ST_IDLE;
					end else begin
						idx_d     = '0;
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = dnle_pkg::ST_DATA;
					end
				end
			end
			dnle_pkg::ST_DATA: begin
				// ram_rdata holds the byte at idx_q
				if (free) begin
					ld      = 1'b1;
					ld_byte = ram_rdata;
					ld_root = final_q && lbl_end;
					ld_last = final_q && lbl_end;
					if (lbl_end) begin
						lcnt_d  = '0;
						state_d = dnle_pkg::ST_IDLE;
					end else begin
						idx_d     = idx_nxt;
						ram_re    = 1'b1;
						ram_raddr = AW'(idx_nxt);
					end
				end
			end
			dnle_pkg::ST_ERR: begin
				if (free) begin
					ld      = 1'b1;
					ld_last = 1'b1;
					ld_err  = ecode_q;
					state_d = dnle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dnle_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dnle_pkg::ST_IDLE;
			lcnt_q     <= '0;
			idx_q      <= '0;
			ncnt_q     <= '0;
			err_hold_q <= 1'b0;
			final_q    <= 1'b0;
			ecode_q    <= dnle_pkg::ERR_NONE;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			lcnt_q     <= lcnt_d;
			idx_q      <= idx_d;
			ncnt_q     <= ncnt_d;
			err_hold_q <= err_hold_d;
			final_q    <= final_d;
			ecode_q    <= ecode_d;
			if (free) begin
				ov_q <= ld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			obyte_q <= ld_byte;
			oroot_q <= ld_root;
			olast_q <= ld_last;
			oerr_q  <= ld_err;
		end
	end

	assign out_valid    = ov_q;
	assign out_byte     = obyte_q;
	assign root_follows = oroot_q;
	assign last         = olast_q;
	assign error_code   = oerr_q;

endmodule
`default_nettype wire

/* rtl/core/dnle_chk.sv */
`default_nettype none
module dnle_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] ch,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       root_follows,
	input wire logic       last,
	input wire logic [1:0] error_code
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
			&& $stable(root_follows) && $stable(error_code))
		else $error("output changed while stalled");

	// error transfers are a bare terminator
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != dnle_pkg::ERR_NONE)
			|-> last && !root_follows && (out_byte == 8'h00))
		else $error("malformed error transfer");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == dnle_pkg::ERR_NONE) || (error_code == dnle_pkg::ERR_NAME)
			|| (error_code == dnle_pkg::ERR_LABEL))
		else $error("unknown error code");

	a_root_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_follows |-> last)
		else $error("root_follows without last");

endmodule

bind dns_name_label_encoder dnle_chk u_dnle_chk (.*);
`default_nettype wire
